>>> src/crc16_framed_packet_receiver_defines.svh
// Assertion macros shared by the receiver RTL.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef CRC16_FRAMED_PACKET_RECEIVER_DEFINES_SVH
`define CRC16_FRAMED_PACKET_RECEIVER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check that a condition holds at every clock edge.
`define CRCFR_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Check that the consequent holds in the same cycle as the antecedent.
`define CRCFR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check that the consequent holds in the cycle after the antecedent.
`define CRCFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CRCFR_ASSERT(lbl, expr, msg)
`define CRCFR_ASSERT_IMPL(lbl, ante, cons, msg)
`define CRCFR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> src/crcfr_pkg.sv
`default_nettype none

package crcfr_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_START_BYTE   = 2'd0;
    localparam logic [1:0] CFG_END_BYTE     = 2'd1;
    localparam logic [1:0] CFG_LENGTH_LIMIT = 2'd2;

    // Reset values of the configuration registers
    localparam logic [7:0]  START_BYTE_RST   = 8'hAA;
    localparam logic [7:0]  END_BYTE_RST     = 8'h55;
    localparam logic [8:0]  LENGTH_LIMIT_RST = 9'd80;

    // Frame and checksum constants
    localparam logic [7:0]  MIN_LEN  = 8'd5;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Live configuration, plus the CRC of the start byte from the init value
    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  end_byte;
        logic [8:0]  length_limit;
        logic [15:0] hdr_crc;
    } cfg_t;

    // One result beat
    typedef struct packed {
        logic [7:0] echo_byte;
        logic       in_frame;
        logic [7:0] byte_index;
        logic       frame_end;
        logic       frame_good;
        logic       crc_bad;
        logic       tail_bad;
        logic [7:0] frame_length;
    } res_t;

    // CRC-16/Modbus update over one byte, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/crcfr_cfg.sv
`default_nettype none

module crcfr_cfg (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire logic [1:0]      wr_index,
    input  wire logic [8:0]      wr_data,
    output crcfr_pkg::cfg_t      cfg
);
    import crcfr_pkg::*;

    logic [7:0]  start_byte_reg;
    logic [7:0]  end_byte_reg;
    logic [8:0]  length_limit_reg;
    logic [15:0] hdr_crc_reg;

    // Write registers; keep the header CRC in step with the start byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg   <= START_BYTE_RST;
            end_byte_reg     <= END_BYTE_RST;
            length_limit_reg <= LENGTH_LIMIT_RST;
            hdr_crc_reg      <= crc_byte(CRC_INIT, START_BYTE_RST);
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_START_BYTE:
                begin
                    start_byte_reg <= wr_data[7:0];
                    hdr_crc_reg    <= crc_byte(CRC_INIT, wr_data[7:0]);
                end
                CFG_END_BYTE:     end_byte_reg     <= wr_data[7:0];
                CFG_LENGTH_LIMIT: length_limit_reg <= wr_data;
                default:          ;
            endcase
        end
    end

    assign cfg.start_byte   = start_byte_reg;
    assign cfg.end_byte     = end_byte_reg;
    assign cfg.length_limit = length_limit_reg;
    assign cfg.hdr_crc      = hdr_crc_reg;

endmodule

`default_nettype wire

>>> src/crcfr_core.sv
`default_nettype none

module crcfr_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic [7:0]      data_byte,
    input  wire crcfr_pkg::cfg_t cfg,
    output crcfr_pkg::res_t      res
);
    import crcfr_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    logic [1:0]  phase_reg,  phase_next;
    logic [7:0]  len_reg,    len_next;
    logic [7:0]  pos_reg,    pos_next;
    logic [15:0] crc_reg,    crc_next;
    logic        fail_reg,   fail_next;

    logic [8:0]  pos_p3;
    logic [8:0]  pos_p2;
    logic [8:0]  len_ext;
    logic        len_ok;

    assign pos_p3  = {1'b0, pos_reg} + 9'd3;
    assign pos_p2  = {1'b0, pos_reg} + 9'd2;
    assign len_ext = {1'b0, len_reg};
    assign len_ok  = (data_byte >= MIN_LEN) && ({1'b0, data_byte} < cfg.length_limit);

    // Decode the byte against the frame state
    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        fail_next  = fail_reg;

        res.echo_byte    = data_byte;
        res.in_frame     = 1'b0;
        res.byte_index   = 8'd0;
        res.frame_end    = 1'b0;
        res.frame_good   = 1'b0;
        res.crc_bad      = 1'b0;
        res.tail_bad     = 1'b0;
        res.frame_length = 8'd0;

        case (phase_reg)
            PH_BODY:
            begin
                res.in_frame     = 1'b1;
                res.byte_index   = pos_reg;
                res.frame_length = len_reg;
                if (pos_p3 < len_ext)
                begin
                    // payload byte: fold into the checksum
                    crc_next = crc_byte(crc_reg, data_byte);
                end
                else if (pos_p3 == len_ext)
                begin
                    if (data_byte != crc_reg[7:0])
                        fail_next = 1'b1;
                end
                else if (pos_p2 == len_ext)
                begin
                    if (data_byte != crc_reg[15:8])
                        fail_next = 1'b1;
                end
                else
                begin
                    // tail byte: report and go back to hunting
                    res.frame_end  = 1'b1;
                    res.crc_bad    = fail_reg;
                    res.tail_bad   = (data_byte != cfg.end_byte);
                    res.frame_good = !fail_reg && (data_byte == cfg.end_byte);
                    phase_next     = PH_IDLE;
                end
                pos_next = pos_reg + 8'd1;
            end
            PH_LEN:
            begin
                if (len_ok)
                begin
                    len_next         = data_byte;
                    crc_next         = crc_byte(cfg.hdr_crc, data_byte);
                    fail_next        = 1'b0;
                    pos_next         = 8'd2;
                    phase_next       = PH_BODY;
                    res.in_frame     = 1'b1;
                    res.byte_index   = 8'd1;
                    res.frame_length = data_byte;
                end
                else if (data_byte == cfg.start_byte)
                    phase_next = PH_LEN;
                else
                    phase_next = PH_IDLE;
            end
            default:
            begin
                if (data_byte == cfg.start_byte)
                    phase_next = PH_LEN;
                else
                    phase_next = PH_IDLE;
            end
        endcase
    end

    // Advance the frame state once per beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            len_reg   <= 8'd0;
            pos_reg   <= 8'd0;
            crc_reg   <= CRC_INIT;
            fail_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            fail_reg  <= fail_next;
        end
    end

endmodule

`default_nettype wire

>>> src/crc16_framed_packet_receiver.sv
// Channel   Handshake               Payload
// -------   ---------------------   -----------------------------------------------
// in        in_valid / in_ready     data_byte
// out       out_valid / out_ready   echo_byte, in_frame, byte_index, frame_end,
//                                   frame_good, crc_bad, tail_bad, frame_length
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data (cfg_ready is always high)
//
// One beat per cycle sustained while out_ready stays high; the result is registered.
// A beat sits in the input register, the frame decode and byte-wide CRC update run
// between it and the result register, and the frame state updates as it moves on.
// Reset (rst_n low, asynchronous) empties both registers and starts hunting for a header.
// A stalled output holds its result; the input register keeps taking beats while the
// result register can move.
`default_nettype none

`include "crc16_framed_packet_receiver_defines.svh"

module crc16_framed_packet_receiver (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output wire logic       in_ready,
    input  wire logic [7:0] data_byte,
    output wire logic       out_valid,
    input  wire logic       out_ready,
    output wire logic [7:0] echo_byte,
    output wire logic       in_frame,
    output wire logic [7:0] byte_index,
    output wire logic       frame_end,
    output wire logic       frame_good,
    output wire logic       crc_bad,
    output wire logic       tail_bad,
    output wire logic [7:0] frame_length,
    input  wire logic       cfg_valid,
    output wire logic       cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [8:0] cfg_data
);
    import crcfr_pkg::*;

    cfg_t       cfg;
    res_t       res;
    res_t       out_reg;
    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_byte_reg;
    logic       out_vld_reg, out_vld_next;
    logic       advance;
    logic       in_take;

    assign cfg_ready = 1'b1;

    crcfr_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    crcfr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_byte_reg),
        .cfg       (cfg),
        .res       (res)
    );

    // Move a beat on when the result register is empty or being drained
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;
    assign in_take  = in_valid && in_ready;

    assign in_vld_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
    assign out_vld_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_vld_reg);

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Load payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_byte_reg <= data_byte;
        if (advance)
            out_reg <= res;
    end

    assign out_valid    = out_vld_reg;
    assign echo_byte    = out_reg.echo_byte;
    assign in_frame     = out_reg.in_frame;
    assign byte_index   = out_reg.byte_index;
    assign frame_end    = out_reg.frame_end;
    assign frame_good   = out_reg.frame_good;
    assign crc_bad      = out_reg.crc_bad;
    assign tail_bad     = out_reg.tail_bad;
    assign frame_length = out_reg.frame_length;

    `CRCFR_ASSERT_NEXT(a_adv_valid, advance, out_valid, "result missing after advance")
    `CRCFR_ASSERT_NEXT(a_in_hold, in_vld_reg && !advance,
        in_vld_reg && $stable(in_byte_reg), "input beat lost while stalled")
    `CRCFR_ASSERT_IMPL(a_end_index, out_valid && frame_end,
        in_frame && (byte_index == frame_length - 8'd1), "frame end at wrong index")
    `CRCFR_ASSERT(a_good_flags, !(out_valid && frame_good && (crc_bad || tail_bad)),
        "frame good with error flag")

endmodule

`default_nettype wire

>>> tb/rx_frame_checker.sv
`default_nettype none

module rx_frame_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire logic [7:0] echo_byte,
    input  wire logic       in_frame,
    input  wire logic [7:0] byte_index,
    input  wire logic       frame_end,
    input  wire logic       frame_good,
    input  wire logic       crc_bad,
    input  wire logic       tail_bad,
    input  wire logic [7:0] frame_length,
    input  wire logic       cfg_valid,
    input  wire logic       cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [8:0] cfg_data,
    output int              mismatch_count,
    output int              results_pending
);
    import crcfr_pkg::*;

    typedef enum logic [1:0] {HUNT, WAIT_LEN, COLLECT} rx_phase_e;

    // Live copy of the configuration registers
    logic [7:0] hdr_value;
    logic [7:0] tail_value;
    logic [8:0] len_limit;

    // Frame tracking state of the predictor
    rx_phase_e   phase_q;
    int          decl_len;
    int          next_pos;
    logic [15:0] crc_acc;
    logic        check_fail;

    res_t expected_results[$];

    // Reflected CRC-16 with poly 0xA001, one byte, LSB first
    function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc,
                                                    input logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {8'h00, b};
        repeat (8)
            r = r[0] ? ({1'b0, r[15:1]} ^ CRC_POLY) : {1'b0, r[15:1]};
        return r;
    endfunction

    // Advance the frame state by one byte and form the result it produces
    task automatic predict_frame_byte(input logic [7:0] b, output res_t r);
        r = '0;
        r.echo_byte = b;
        case (phase_q)
            COLLECT:
            begin
                r.in_frame     = 1'b1;
                r.byte_index   = 8'(next_pos);
                r.frame_length = 8'(decl_len);
                if (next_pos + 3 < decl_len)
                    crc_acc = modbus_crc_step(crc_acc, b);
                else if (next_pos + 3 == decl_len)
                begin
                    if (b != crc_acc[7:0])
                        check_fail = 1'b1;
                end
                else if (next_pos + 2 == decl_len)
                begin
                    if (b != crc_acc[15:8])
                        check_fail = 1'b1;
                end
                else
                begin
                    r.frame_end  = 1'b1;
                    r.crc_bad    = check_fail;
                    r.tail_bad   = (b != tail_value);
                    r.frame_good = !check_fail && (b == tail_value);
                    phase_q      = HUNT;
                end
                next_pos = (next_pos + 1) & 8'hFF;
            end
            WAIT_LEN:
            begin
                if (b >= MIN_LEN && {1'b0, b} < len_limit)
                begin
                    decl_len       = b;
                    crc_acc        = modbus_crc_step(modbus_crc_step(CRC_INIT, hdr_value), b);
                    check_fail     = 1'b0;
                    next_pos       = 2;
                    phase_q        = COLLECT;
                    r.in_frame     = 1'b1;
                    r.byte_index   = 8'd1;
                    r.frame_length = b;
                end
                else if (b == hdr_value)
                    phase_q = WAIT_LEN;
                else
                    phase_q = HUNT;
            end
            default:
                phase_q = (b == hdr_value) ? WAIT_LEN : HUNT;
        endcase
    endtask

    // Print one line and count; keep the log bounded on a badly broken block
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("%0t: %s mismatch, got %0d, want %0d", $time, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (!rst_n)
        begin
            hdr_value  = START_BYTE_RST;
            tail_value = END_BYTE_RST;
            len_limit  = LENGTH_LIMIT_RST;
            phase_q    = HUNT;
            decl_len   = 0;
            next_pos   = 0;
            crc_acc    = CRC_INIT;
            check_fail = 1'b0;
            expected_results.delete();
        end
        else
        begin
            // Register writes; unmapped indexes drop
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_START_BYTE:   hdr_value  = cfg_data[7:0];
                    CFG_END_BYTE:     tail_value = cfg_data[7:0];
                    CFG_LENGTH_LIMIT: len_limit  = cfg_data;
                    default: ;
                endcase
            end

            // Compare the result beat before queueing a new expectation
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result beat, echo_byte", echo_byte, 0);
                else
                begin
                    want = expected_results.pop_front();
                    check_field("echo_byte", echo_byte, want.echo_byte);
                    check_field("in_frame", {7'd0, in_frame}, {7'd0, want.in_frame});
                    check_field("byte_index", byte_index, want.byte_index);
                    check_field("frame_end", {7'd0, frame_end}, {7'd0, want.frame_end});
                    check_field("frame_good", {7'd0, frame_good}, {7'd0, want.frame_good});
                    check_field("crc_bad", {7'd0, crc_bad}, {7'd0, want.crc_bad});
                    check_field("tail_bad", {7'd0, tail_bad}, {7'd0, want.tail_bad});
                    check_field("frame_length", frame_length, want.frame_length);
                end
            end

            // Predict the result of an accepted input beat
            if (in_valid && in_ready)
            begin
                predict_frame_byte(data_byte, want);
                expected_results.push_back(want);
            end
        end
        results_pending = expected_results.size();
    end

endmodule

`default_nettype wire

>>> tb/tb.sv
`default_nettype none

module tb;
    import crcfr_pkg::*;

    // Register index with no register behind it
    localparam logic [1:0] CFG_SPARE = 2'd3;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] echo_byte;
    logic       in_frame;
    logic [7:0] byte_index;
    logic       frame_end;
    logic       frame_good;
    logic       crc_bad;
    logic       tail_bad;
    logic [7:0] frame_length;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [8:0] cfg_data;

    int mismatch_count;
    int results_pending;

    // Idle controls for the sender and the receiver, and a count of frame beats sent
    int send_gap_max;
    int recv_gap_max;
    int recv_hold_request;
    int frame_beats;

    // Configuration the stimulus is built against
    logic [7:0] cur_start;
    logic [7:0] cur_end;
    logic [8:0] cur_limit;

    crc16_framed_packet_receiver u_top (.*);

    rx_frame_checker u_checker (.*);

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: stall a random count after each beat, or hold off on request
    initial
    begin
        int stall;
        stall     = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (recv_hold_request > 0)
            begin
                stall             = recv_hold_request;
                recv_hold_request = 0;
            end
            out_ready = (stall == 0);
            if (stall > 0)
                stall--;
            @(posedge clk);
            if (out_valid && out_ready)
                stall = $urandom_range(0, recv_gap_max);
        end
    end

    // Offer one beat after a random gap and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        data_byte = b;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Stop offering and wait until every result has come back
    task automatic wait_drained();
        in_valid = 1'b0;
        while (results_pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_config(input logic [8:0] start_v, input logic [8:0] end_v,
                                input logic [8:0] limit_v);
        write_reg(CFG_START_BYTE, start_v);
        write_reg(CFG_END_BYTE, end_v);
        write_reg(CFG_LENGTH_LIMIT, limit_v);
        cur_start = start_v[7:0];
        cur_end   = end_v[7:0];
        cur_limit = limit_v;
    endtask

    function automatic int max_frame_len();
        return (cur_limit > 9'd255) ? 255 : int'(cur_limit) - 1;
    endfunction

    // Mostly short frames, now and then up to the longest allowed
    function automatic int frame_len(input int max_len);
        int r;
        r = $urandom_range(0, 49);
        if (r == 0)
            return max_len;
        if (r < 5)
            return $urandom_range(MIN_LEN, max_len);
        return $urandom_range(MIN_LEN, (max_len < 20) ? max_len : 20);
    endfunction

    // Send a whole frame; flaw bits corrupt CRC low, CRC high and tail
    task automatic send_frame(input int len, input logic [2:0] flaw);
        logic [15:0] crc;
        logic [7:0]  b;
        crc = crc_byte(CRC_INIT, cur_start);
        send_byte(cur_start);
        crc = crc_byte(crc, len[7:0]);
        send_byte(len[7:0]);
        for (int i = 2; i < len - 3; i++)
        begin
            b   = 8'($urandom);
            crc = crc_byte(crc, b);
            send_byte(b);
        end
        send_byte(crc[7:0] ^ (flaw[0] ? 8'($urandom_range(1, 255)) : 8'h00));
        send_byte(crc[15:8] ^ (flaw[1] ? 8'($urandom_range(1, 255)) : 8'h00));
        send_byte(cur_end ^ (flaw[2] ? 8'($urandom_range(1, 255)) : 8'h00));
        frame_beats += len;
    endtask

    // Loose bytes, often the start byte
    task automatic send_noise();
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(0, 3) == 0)
                send_byte(cur_start);
            else
                send_byte(8'($urandom));
        end
    endtask

    // Rejected lengths, doubled headers and cut-off frames
    task automatic send_broken();
        logic [7:0] b;
        case ($urandom_range(0, 2))
            0:
            begin
                send_byte(cur_start);
                if ($urandom_range(0, 1) == 0 || cur_limit > 9'd255)
                    b = 8'($urandom_range(0, MIN_LEN - 1));
                else
                    b = 8'($urandom_range(int'(cur_limit), 255));
                send_byte(b);
            end
            1:
            begin
                repeat ($urandom_range(1, 2)) send_byte(cur_start);
                send_frame(frame_len(max_frame_len()), 3'b000);
            end
            default:
            begin
                send_byte(cur_start);
                send_byte(8'(frame_len(max_frame_len())));
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
                send_frame(frame_len(max_frame_len()), 3'b000);
            end
        endcase
    endtask

    // Random traffic until the given number of frame beats has gone in
    task automatic run_random(input int budget);
        int target;
        int pick;
        logic [2:0] flaw;
        target = frame_beats + budget;
        while (frame_beats < target)
        begin
            // switch idle modes now and then, zero meaning back to back
            if ($urandom_range(0, 19) == 0)
            begin
                send_gap_max = 10 * $urandom_range(0, 1);
                recv_gap_max = 10 * $urandom_range(0, 1);
            end
            if ($urandom_range(0, 49) == 0)
                wait_drained();
            pick = $urandom_range(0, 99);
            flaw = ($urandom_range(0, 9) < 7) ? 3'b000 : 3'($urandom_range(1, 7));
            if (pick < 15)
                send_noise();
            else if (pick < 25)
                send_broken();
            else
                send_frame(frame_len(max_frame_len()), flaw);
        end
    endtask

    initial
    begin
        in_valid          = 1'b0;
        data_byte         = 8'h00;
        cfg_valid         = 1'b0;
        cfg_index         = CFG_START_BYTE;
        cfg_data          = 9'h000;
        send_gap_max      = 3;
        recv_gap_max      = 3;
        recv_hold_request = 0;
        frame_beats       = 0;
        cur_start         = START_BYTE_RST;
        cur_end           = END_BYTE_RST;
        cur_limit         = LENGTH_LIMIT_RST;
        rst_n             = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed: field extremes, rejected lengths, header twice, each flaw
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(cur_start);
        send_byte(8'd4);
        send_byte(cur_start);
        send_frame(5, 3'b000);
        send_byte(cur_start);
        send_byte(8'(cur_limit));
        send_frame(6, 3'b101);
        send_frame(5, 3'b010);
        wait_drained();

        run_random(200);
        wait_drained();

        // Widest limit; fill the block behind a long receiver hold-off
        apply_config({1'b1, 8'h00}, 9'h0FF, 9'd256);
        send_gap_max      = 0;
        recv_hold_request = 80;
        send_frame(255, 3'b000);
        run_random(250);
        wait_drained();

        // Tightest limit: only five-byte frames get through
        apply_config(9'h0FF, 9'h100, 9'd6);
        run_random(150);
        wait_drained();

        // Limit too low for any frame; spare index must change nothing
        apply_config(9'($urandom), 9'($urandom), 9'd3);
        write_reg(CFG_SPARE, 9'($urandom));
        repeat (20)
        begin
            send_noise();
            send_frame($urandom_range(5, 40), 3'b000);
        end
        wait_drained();

        repeat (3)
        begin
            apply_config(9'($urandom), 9'($urandom), 9'($urandom_range(6, 256)));
            run_random(100);
            wait_drained();
        end

        repeat (10) @(negedge clk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
